/* src/lv3_pkg.sv */
// Package for the 3x3 local variance filter: widths, codes, controller states
// and the command/status structures that join the controller and the datapath.
// No dependencies.
package lv3_pkg;

    // Field widths.
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 10;
    localparam int SIZE_W   = 11;
    localparam int VAR_W    = 22;
    localparam int S1_W     = 12;
    localparam int S2_W     = 20;
    localparam int PROD_W   = 23;
    localparam int NSQ_W    = 7;
    localparam int DIVD_W   = PROD_W + 8;
    localparam int M_DATA_W = 48;

    // The divider produces one quotient bit per cycle.
    localparam int DIV_STEPS = DIVD_W;

    // Height limit and the largest variance a window of 8-bit pixels can give.
    localparam logic [SIZE_W-1:0] HEIGHT_CAP = 11'd1024;
    localparam logic [VAR_W-1:0]  VAR_MAX    = 22'd4161600;

    // Stream item kinds carried on tuser.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ACC,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic shift;
        logic acc_step;
        logic mul;
        logic div_load;
        logic div_step;
        logic out_load;
        logic restart;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;
        logic emit;
        logic tap_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

/* src/lv3_ctrl.sv */
// Controller of the 3x3 local variance filter: sequences capture, window shift,
// tap accumulation, products, division and result hand-off.
// Depends on lv3_pkg.
module lv3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_cfg_write,
    input  lv3_pkg::t_status i_status,
    output lv3_pkg::t_cmd    o_cmd,
    output logic             o_s_ready
);

    lv3_pkg::t_state r_state;
    lv3_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lv3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        o_cmd.restart = i_cfg_write;
        unique case (r_state)
            lv3_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                // A drain tick before the frame is complete is dropped here.
                if (i_s_valid && !i_status.drop) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lv3_pkg::ST_SHIFT;
                end
            end
            lv3_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.emit ? lv3_pkg::ST_ACC : lv3_pkg::ST_IDLE;
            end
            lv3_pkg::ST_ACC: begin
                o_cmd.acc_step = 1'b1;
                if (i_status.tap_last) begin
                    n_state = lv3_pkg::ST_MUL;
                end
            end
            lv3_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = lv3_pkg::ST_PREP;
            end
            lv3_pkg::ST_PREP: begin
                o_cmd.div_load = 1'b1;
                n_state        = lv3_pkg::ST_DIV;
            end
            lv3_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = lv3_pkg::ST_OUT;
                end
            end
            lv3_pkg::ST_OUT: begin
                // Wait until the output register is free or being emptied.
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lv3_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lv3_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/lv3_dp.sv */
// Datapath of the 3x3 local variance filter: line stores, 3x3 window, stream
// positions, tap accumulator, products, bit-serial divider and output register.
// Depends on lv3_pkg.
module lv3_dp #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lv3_pkg::t_cmd                 i_cmd,
    output lv3_pkg::t_status              o_status,
    input  logic                          i_func,
    input  logic [lv3_pkg::PIX_W-1:0]     i_pixel,
    input  logic [lv3_pkg::SIZE_W-1:0]    i_width,
    input  logic [lv3_pkg::SIZE_W-1:0]    i_height,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [lv3_pkg::VAR_W-1:0]     o_variance,
    output logic [lv3_pkg::COORD_W-1:0]   o_row,
    output logic [lv3_pkg::COORD_W-1:0]   o_col,
    output logic                          o_frame_end
);

    localparam int AW = $clog2(STORE_DEPTH);

    // Line stores: previous row and the row before it.
    logic [lv3_pkg::PIX_W-1:0] r_store_a [STORE_DEPTH];
    logic [lv3_pkg::PIX_W-1:0] r_store_b [STORE_DEPTH];

    logic [lv3_pkg::PIX_W-1:0]   r_pix;
    logic [lv3_pkg::PIX_W-1:0]   r_top;
    logic [lv3_pkg::PIX_W-1:0]   r_mid;
    logic [AW-1:0]               r_addr;
    logic [lv3_pkg::PIX_W-1:0]   r_win [3][3];

    logic [lv3_pkg::SIZE_W-1:0]  r_in_row;
    logic [lv3_pkg::COORD_W-1:0] r_in_col;
    logic [lv3_pkg::COORD_W-1:0] r_out_row;
    logic [lv3_pkg::COORD_W-1:0] r_out_col;

    logic [1:0]                  r_tr;
    logic [1:0]                  r_tc;
    logic [3:0]                  r_n;
    logic [lv3_pkg::S1_W-1:0]    r_s1;
    logic [lv3_pkg::S2_W-1:0]    r_s2;
    logic [lv3_pkg::PROD_W-1:0]  r_ns2;
    logic [lv3_pkg::PROD_W-1:0]  r_s1sq;
    logic [lv3_pkg::NSQ_W-1:0]   r_nsq;
    logic [lv3_pkg::DIVD_W-1:0]  r_quo;
    logic [lv3_pkg::NSQ_W-1:0]   r_rem;
    logic [4:0]                  r_dcnt;
    logic                        r_out_valid;

    logic                        w_draining;
    logic [lv3_pkg::COORD_W-1:0] w_row_last;
    logic [lv3_pkg::COORD_W-1:0] w_col_last;
    logic                        w_last;
    logic                        w_row_ok;
    logic                        w_col_ok;
    logic [lv3_pkg::PIX_W-1:0]   w_tap;
    logic [15:0]                 w_sq;
    logic [23:0]                 w_ns2;
    logic [23:0]                 w_s1sq;
    logic [7:0]                  w_nsq;
    logic [lv3_pkg::NSQ_W:0]     w_trial;
    logic [lv3_pkg::NSQ_W:0]     w_sub;
    logic                        w_ge;

    // Frame position decode.
    assign w_draining = (r_in_row >= i_height);
    assign w_row_last = 10'(i_height - 11'd1);
    assign w_col_last = 10'(i_width - 11'd1);
    assign w_last     = (r_out_row == w_row_last) && (r_out_col == w_col_last);

    assign o_status.drop     = (i_func == lv3_pkg::FUNC_DRAIN) && !w_draining;
    assign o_status.emit     = (r_in_row >= 11'd2) || ((r_in_row == 11'd1) && (r_in_col != '0));
    assign o_status.tap_last = (r_tr == 2'd2) && (r_tc == 2'd2);
    assign o_status.div_last = (r_dcnt == 5'(lv3_pkg::DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_m_ready;

    // Capture of the incoming pixel; drain ticks feed zeros.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix  <= w_draining ? '0 : i_pixel;
            r_addr <= r_in_col[AW-1:0];
        end
    end

    // Line store A: read on capture, written with the new pixel on shift.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mid <= r_store_a[r_in_col[AW-1:0]];
        end
        if (i_cmd.shift) begin
            r_store_a[r_addr] <= r_pix;
        end
    end

    // Line store B: takes the row that line store A held.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_top <= r_store_b[r_in_col[AW-1:0]];
        end
        if (i_cmd.shift) begin
            r_store_b[r_addr] <= r_mid;
        end
    end

    // Window: shifts a column per item; reset, restart and frame end clear it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart || (i_cmd.out_load && w_last)) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_top;
            r_win[1][2] <= r_mid;
            r_win[2][2] <= r_pix;
        end
    end

    // Input and output stream positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            if (i_cmd.shift) begin
                if ({1'b0, r_in_col} + 11'd1 >= i_width) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 11'd1;
                end else begin
                    r_in_col <= r_in_col + 10'd1;
                end
            end
            if (i_cmd.out_load) begin
                if (w_last) begin
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_out_row <= '0;
                    r_out_col <= '0;
                end else if ({1'b0, r_out_col} + 11'd1 >= i_width) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 10'd1;
                end else begin
                    r_out_col <= r_out_col + 10'd1;
                end
            end
        end
    end

    // Tap selection and clipping to the image edges.
    assign w_tap = r_win[r_tr][r_tc];
    always_comb begin
        case (r_tr)
            2'd0:    w_row_ok = (r_out_row != '0);
            2'd2:    w_row_ok = (r_out_row != w_row_last);
            default: w_row_ok = 1'b1;
        endcase
        case (r_tc)
            2'd0:    w_col_ok = (r_out_col != '0);
            2'd2:    w_col_ok = (r_out_col != w_col_last);
            default: w_col_ok = 1'b1;
        endcase
    end
    assign w_sq = 16'(w_tap) * 16'(w_tap);

    // Tap walk: one tap per cycle into count, sum and sum of squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.shift) begin
            r_tr <= '0;
            r_tc <= '0;
        end else if (i_cmd.acc_step) begin
            if (r_tc == 2'd2) begin
                r_tc <= '0;
                r_tr <= r_tr + 2'd1;
            end else begin
                r_tc <= r_tc + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_n  <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (i_cmd.acc_step && w_row_ok && w_col_ok) begin
            r_n  <= r_n + 4'd1;
            r_s1 <= r_s1 + 12'(w_tap);
            r_s2 <= r_s2 + 20'(w_sq);
        end
    end

    // Products n*S2, S1*S1 and n*n.
    assign w_ns2  = 24'(r_n) * 24'(r_s2);
    assign w_s1sq = 24'(r_s1) * 24'(r_s1);
    assign w_nsq  = 8'(r_n) * 8'(r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_ns2  <= w_ns2[lv3_pkg::PROD_W-1:0];
            r_s1sq <= w_s1sq[lv3_pkg::PROD_W-1:0];
            r_nsq  <= w_nsq[lv3_pkg::NSQ_W-1:0];
        end
    end

    // Restoring divider: 256*(n*S2 - S1^2) / n^2, one quotient bit a cycle.
    assign w_trial = {r_rem, r_quo[lv3_pkg::DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_nsq});
    assign w_sub   = w_trial - {1'b0, r_nsq};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= {r_ns2 - r_s1sq, 8'd0};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[lv3_pkg::NSQ_W-1:0] : w_trial[lv3_pkg::NSQ_W-1:0];
            r_quo <= {r_quo[lv3_pkg::DIVD_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.div_load) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    // Output register: holds one result until the downstream transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_variance  <= r_quo[lv3_pkg::VAR_W-1:0];
            o_row       <= r_out_row;
            o_col       <= r_out_col;
            o_frame_end <= w_last;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

/* src/local_variance_3x3.sv */
// A result reaches the output register after its item's transfer, the shift, the
// nine-tap walk, the products, the divider steps and the load, later while a stalled result waits.
// Items are taken one at a time, paced by the nine-tap walk and the bit-serial divider; an item
// without a result needs only the shift, and a dropped drain is taken while idle.
// Reset (synchronous, active low): frame size 640 x 480, positions and window cleared,
// output empty; the line stores are not cleared.
module local_variance_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lv3_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
    input  logic                            s_tuser,   // [0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lv3_pkg::M_DATA_W-1:0]    m_tdata,   // [21:0] variance_q8, [31:22] row,
                                                       // [41:32] col, [47:42] zero
    output logic                            m_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [lv3_pkg::SIZE_W-1:0]      i_cfg_data
);

    localparam int STORE_DEPTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [lv3_pkg::SIZE_W-1:0] WIDTH_CAP = 11'(STORE_DEPTH);

    logic [lv3_pkg::SIZE_W-1:0] r_frame_width;
    logic [lv3_pkg::SIZE_W-1:0] r_frame_height;
    logic [lv3_pkg::SIZE_W-1:0] w_width;
    logic [lv3_pkg::SIZE_W-1:0] w_height;
    logic                       w_cfg_write;

    lv3_pkg::t_cmd    w_cmd;
    lv3_pkg::t_status w_status;

    logic [lv3_pkg::VAR_W-1:0]   w_variance;
    logic [lv3_pkg::COORD_W-1:0] w_row;
    logic [lv3_pkg::COORD_W-1:0] w_col;

    // Configuration registers; every write restarts the frame.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 11'd480;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                lv3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                lv3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
            endcase
        end
    end

    // Sizes in use: zero counts as one, large values are capped.
    always_comb begin
        w_width = r_frame_width;
        if (w_width == '0) begin
            w_width = 11'd1;
        end else if (w_width > WIDTH_CAP) begin
            w_width = WIDTH_CAP;
        end
        w_height = r_frame_height;
        if (w_height == '0) begin
            w_height = 11'd1;
        end else if (w_height > lv3_pkg::HEIGHT_CAP) begin
            w_height = lv3_pkg::HEIGHT_CAP;
        end
    end

    lv3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_tvalid),
        .i_cfg_write (w_cfg_write),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_s_ready   (s_tready)
    );

    lv3_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_func      (s_tuser),
        .i_pixel     (s_tdata),
        .i_width     (w_width),
        .i_height    (w_height),
        .i_m_ready   (m_tready),
        .o_m_valid   (m_tvalid),
        .o_variance  (w_variance),
        .o_row       (w_row),
        .o_col       (w_col),
        .o_frame_end (m_tlast)
    );

    // Result packing, first field in the lowest bits.
    assign m_tdata = {6'd0, w_col, w_row, w_variance};

endmodule

/* src/lv3_checker.sv */
// Port-level checks for the 3x3 local variance filter, bound to the top level.
// Depends on lv3_pkg and local_variance_3x3.
module lv3_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lv3_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tlast
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A pixel transfer is always processed, so the input stalls the next cycle.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && (s_tuser == lv3_pkg::FUNC_PIXEL) |=> !s_tready)
        else $error("input ready after a pixel transfer");

    // The variance of 8-bit pixels cannot exceed a quarter of the full range squared.
    a_var_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[21:0] <= lv3_pkg::VAR_MAX))
        else $error("variance out of range");

    // Padding bits of the result are zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[47:42] == 6'd0))
        else $error("result padding not zero");

endmodule

bind local_variance_3x3 lv3_checker u_lv3_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
